// ===== rtl/core/ffha_pkg.sv =====
// shared constants, codes and types of the first-fit heap allocator
`default_nettype none

package ffha_pkg;

    localparam int HEAP_GRANULES = 256;

    localparam int REQ_W   = 13;
    localparam int OFF_W   = 12;
    localparam int STAT_W  = 2;

    localparam int G_W     = $clog2(HEAP_GRANULES);
    localparam int S_W     = $clog2(HEAP_GRANULES + 1);
    localparam int E_W     = S_W + 1;
    localparam int NEED_W  = REQ_W - 3;
    localparam int TGT_W   = OFF_W - 4;
    localparam int CMP_W   = (S_W > NEED_W) ? S_W : NEED_W;
    localparam int TCMP_W  = (S_W > TGT_W) ? S_W : TGT_W;

    localparam logic [S_W-1:0] HEAP_SIZE = S_W'(HEAP_GRANULES);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_BADPTR = 2'd2
    } t_status;

    typedef struct packed {
        logic           we;
        logic [G_W-1:0] waddr;
        logic [E_W-1:0] wdata;
        logic [G_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== rtl/core/ffha_hdr_store.sv =====
// block header memory, one entry per granule, entry 0 reads as the whole free heap after reset
`default_nettype none

module ffha_hdr_store (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ffha_pkg::t_mem_req    i_req,
    output logic [ffha_pkg::E_W-1:0]   o_rdata
);
    import ffha_pkg::*;

    logic [E_W-1:0] r_mem [HEAP_GRANULES];
    logic [E_W-1:0] r_rdata;
    logic           r_rd_init;
    logic           r_e0_written;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_written <= 1'b0;
            r_rd_init    <= 1'b0;
        end else begin
            r_rd_init <= (i_req.raddr == '0) && !r_e0_written;
            if (i_req.we && (i_req.waddr == '0)) begin
                r_e0_written <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rd_init ? {HEAP_SIZE, 1'b0} : r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_core.sv =====
// first-fit heap allocator core: block list walker and header update sequencer
`default_nettype none

// each item walks the headers in order: an allocate takes the first free block that fits
//   and splits off the rest; a free merges a free next block and a free previous block
// throughput: one item at a time, the next accepted while o_done is high; a misaligned free
//   is refused without a header read, other headers are read through a registered port
// reset: synchronous active low, heap becomes one free block spanning all granules; o_done
//   pulses one cycle with o_status and o_granted_offset, the receiver cannot stall
module first_fit_heap_allocator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_operation,
    input  wire logic [ffha_pkg::REQ_W-1:0]    i_request_bytes,
    input  wire logic [ffha_pkg::OFF_W-1:0]    i_user_offset,
    output logic                               o_done,
    output logic [ffha_pkg::STAT_W-1:0]        o_status,
    output logic [ffha_pkg::OFF_W-1:0]         o_granted_offset
);
    import ffha_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RD     = 6'b000010,
        S_EVAL   = 6'b000100,
        S_SPLIT  = 6'b001000,
        S_NXT_EV = 6'b010000,
        S_PREV   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [NEED_W-1:0]   r_need, n_need;
    logic [TGT_W-1:0]    r_target, n_target;
    logic [S_W-1:0]      r_g, n_g;
    logic [S_W-1:0]      r_s, n_s;
    logic                r_have_prev, n_have_prev;
    logic [S_W-1:0]      r_prev, n_prev;
    logic [S_W-1:0]      r_prev_s, n_prev_s;
    logic                r_prev_used, n_prev_used;
    logic                r_nx_ok, n_nx_ok;
    logic                r_done, n_done;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [OFF_W-1:0]    r_off, n_off;

    t_mem_req            w_req;
    logic [E_W-1:0]      w_rdata;
    logic [S_W-1:0]      w_s;
    logic                w_used;
    logic                w_ok;
    logic [S_W-1:0]      w_add_a, w_add_b, w_sum;
    logic [S_W-1:0]      w_room;
    logic [S_W-1:0]      w_need_s;
    logic                w_fits;
    logic                w_exact;
    logic                w_hit;
    logic                w_past;
    logic [S_W+3:0]      w_off_full;
    logic [REQ_W:0]      w_need_sum;

    ffha_hdr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign w_s        = w_rdata[E_W-1:1];
    assign w_used     = w_rdata[0];
    assign w_room     = HEAP_SIZE - r_g;
    assign w_ok       = (w_s != '0) && (w_s <= w_room);
    assign w_need_s   = S_W'(r_need);
    assign w_fits     = !w_used && (CMP_W'(w_s) >= CMP_W'(r_need));
    assign w_exact    = (CMP_W'(w_s) == CMP_W'(r_need));
    assign w_hit      = (TCMP_W'(r_g) == TCMP_W'(r_target));
    assign w_past     = (TCMP_W'(r_g) > TCMP_W'(r_target));
    assign w_off_full = {r_g, 4'b1000};
    assign w_need_sum = (REQ_W+1)'(i_request_bytes) + (REQ_W+1)'(23);
    assign w_sum      = w_add_a + w_add_b;

    // shared adder operand select
    always_comb begin
        w_add_a = r_g;
        w_add_b = w_s;
        unique case (r_state)
            S_SPLIT: begin
                w_add_a = r_g;
                w_add_b = w_need_s;
            end
            S_NXT_EV: begin
                w_add_a = r_s;
                w_add_b = w_s;
            end
            S_PREV: begin
                w_add_a = r_prev_s;
                w_add_b = r_s;
            end
            default: begin
                w_add_a = r_g;
                w_add_b = w_s;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_need      = r_need;
        n_target    = r_target;
        n_g         = r_g;
        n_s         = r_s;
        n_have_prev = r_have_prev;
        n_prev      = r_prev;
        n_prev_s    = r_prev_s;
        n_prev_used = r_prev_used;
        n_nx_ok     = r_nx_ok;
        n_done      = 1'b0;
        n_status    = r_status;
        n_off       = r_off;
        w_req.we    = 1'b0;
        w_req.waddr = r_g[G_W-1:0];
        w_req.wdata = '0;
        w_req.raddr = r_g[G_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op        = t_op'(i_operation);
                    n_need      = w_need_sum[REQ_W:4];
                    n_target    = i_user_offset[OFF_W-1:4];
                    n_g         = '0;
                    n_have_prev = 1'b0;
                    if ((t_op'(i_operation) == OP_FREE) && (i_user_offset[3:0] != 4'b1000)) begin
                        n_done   = 1'b1;
                        n_status = ST_BADPTR;
                        n_off    = '0;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                // read request for the block at r_g goes out here
                if (r_g >= HEAP_SIZE) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = (r_op == OP_ALLOC) ? ST_NOFIT : ST_BADPTR;
                    n_off    = '0;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!w_ok) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = (r_op == OP_ALLOC) ? ST_NOFIT : ST_BADPTR;
                    n_off    = '0;
                end else if (r_op == OP_ALLOC) begin
                    if (w_fits) begin
                        w_req.we    = 1'b1;
                        w_req.wdata = {(w_exact ? w_s : w_need_s), 1'b1};
                        n_s         = w_s - w_need_s;
                        n_off       = OFF_W'(w_off_full);
                        n_status    = ST_OK;
                        if (w_exact) begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_state = S_SPLIT;
                        end
                    end else begin
                        n_g     = w_sum;
                        n_state = S_RD;
                    end
                end else begin
                    if (w_hit) begin
                        if (!w_used) begin
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                            n_status = ST_BADPTR;
                            n_off    = '0;
                        end else begin
                            // look at the next block for a merge
                            n_s         = w_s;
                            n_nx_ok     = (w_sum < HEAP_SIZE);
                            w_req.raddr = w_sum[G_W-1:0];
                            n_state     = S_NXT_EV;
                        end
                    end else if (w_past) begin
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        n_status = ST_BADPTR;
                        n_off    = '0;
                    end else begin
                        n_have_prev = 1'b1;
                        n_prev      = r_g;
                        n_prev_s    = w_s;
                        n_prev_used = w_used;
                        n_g         = w_sum;
                        n_state     = S_RD;
                    end
                end
            end
            S_SPLIT: begin
                w_req.we    = 1'b1;
                w_req.waddr = w_sum[G_W-1:0];
                w_req.wdata = {r_s, 1'b0};
                n_state     = S_IDLE;
                n_done      = 1'b1;
            end
            S_NXT_EV: begin
                // next block size check is relative to its own start
                if (r_nx_ok && (w_s != '0) && (w_s <= (HEAP_SIZE - (r_g + r_s))) && !w_used) begin
                    n_s         = w_sum;
                    w_req.wdata = {w_sum, 1'b0};
                end else begin
                    w_req.wdata = {r_s, 1'b0};
                end
                w_req.we = 1'b1;
                n_status = ST_OK;
                n_off    = '0;
                if (r_have_prev && !r_prev_used) begin
                    n_state = S_PREV;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_PREV: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_prev[G_W-1:0];
                w_req.wdata = {w_sum, 1'b0};
                n_state     = S_IDLE;
                n_done      = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_need      <= n_need;
        r_target    <= n_target;
        r_g         <= n_g;
        r_s         <= n_s;
        r_have_prev <= n_have_prev;
        r_prev      <= n_prev;
        r_prev_s    <= n_prev_s;
        r_prev_used <= n_prev_used;
        r_nx_ok     <= n_nx_ok;
        r_status    <= n_status;
        r_off       <= n_off;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_granted_offset = r_off;

endmodule

`default_nettype wire
